FILE: design/mwuf_pkg.sv
package mwuf_pkg;

  // Field widths of the wall and result transfers
  localparam int COORD_W   = 6;
  localparam int CFG_W     = 7;
  localparam int CELL_W    = 12;
  localparam int IDX_W     = 13;
  localparam int KEPT_W    = 13;
  localparam int RANK_W    = 4;

  localparam logic [KEPT_W-1:0] KEPT_MAX = 13'd8191;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  // Register reset values
  localparam logic [CFG_W-1:0] COLUMNS_RESET = 7'd64;
  localparam logic [CFG_W-1:0] ROWS_RESET    = 7'd64;

  // Register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_COLUMNS = 1'b0;
  localparam cfg_idx_t CFG_ROWS    = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic clr_wr;
    logic calc;
    logic rd_first;
    logic rd_second;
    logic walk_a;
    logic walk_b;
    logic do_merge;
    logic bump;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic bad;
    logic at_root;
    logic bump_need;
  } sts_t;

endpackage

FILE: design/mwuf_ctrl.sv
module mwuf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_restart,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  mwuf_pkg::sts_t sts,
  output mwuf_pkg::cmd_t cmd
);
  import mwuf_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INDEX,
    S_FA_ISSUE,
    S_FA_WALK,
    S_FB_ISSUE,
    S_FB_WALK,
    S_MERGE,
    S_BUMP,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   item_r, item_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Decode state into datapath commands and the next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = item_r ? S_INDEX : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          item_nxt    = 1'b1;
          state_nxt   = in_restart ? S_CLEAR : S_INDEX;
        end
      end
      S_INDEX: begin
        cmd.calc  = 1'b1;
        state_nxt = S_FA_ISSUE;
      end
      S_FA_ISSUE: begin
        if (sts.bad) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_FA_WALK;
        end
      end
      S_FA_WALK: begin
        cmd.walk_a = 1'b1;
        if (sts.at_root) begin
          state_nxt = S_FB_ISSUE;
        end
      end
      S_FB_ISSUE: begin
        cmd.rd_second = 1'b1;
        state_nxt     = S_FB_WALK;
      end
      S_FB_WALK: begin
        cmd.walk_b = 1'b1;
        if (sts.at_root) begin
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd.do_merge = 1'b1;
        state_nxt    = sts.bump_need ? S_BUMP : S_RESULT;
      end
      S_BUMP: begin
        cmd.bump  = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          item_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs; reset starts a clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      item_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      item_r      <= item_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: design/mwuf_dp.sv
module mwuf_dp #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mwuf_pkg::cmd_t                cmd,
  output mwuf_pkg::sts_t                sts,
  input  logic [mwuf_pkg::CFG_W-1:0]    columns,
  input  logic [mwuf_pkg::CFG_W-1:0]    rows,
  input  logic [mwuf_pkg::COORD_W-1:0]  in_cell_x,
  input  logic [mwuf_pkg::COORD_W-1:0]  in_cell_y,
  input  logic                          in_orientation,
  output logic                          out_keep,
  output logic [mwuf_pkg::CELL_W-1:0]   out_first_cell,
  output logic [mwuf_pkg::CELL_W-1:0]   out_second_cell,
  output logic                          out_invalid,
  output logic [mwuf_pkg::KEPT_W-1:0]   out_walls_kept
);
  import mwuf_pkg::*;

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int IW         = $clog2(CELL_COUNT);
  localparam int ENT_W      = IW + RANK_W;
  localparam int LIM_W      = 9;

  // Forest memory: parent link over rank in each entry
  logic [ENT_W-1:0] mem [CELL_COUNT];
  logic [ENT_W-1:0] rd_data_r;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [ENT_W-1:0] wr_data;

  logic [COORD_W-1:0] x_r, y_r;
  logic               up_r;
  logic [IDX_W-1:0]   first_r, first_nxt, second_r, second_nxt;
  logic               bad_r, bad_nxt;
  logic [IW-1:0]      node_r, node_nxt;
  logic [IW-1:0]      root_a_r;
  logic [RANK_W-1:0]  rank_a_r, rank_b_r;
  logic               keep_r;
  logic [KEPT_W-1:0]  kept_r;
  logic [IW-1:0]      clr_cnt_r;

  logic [CFG_W-1:0]   cols, rws;
  logic [IW-1:0]      rd_parent;
  logic [RANK_W-1:0]  rd_rank;
  logic               at_root, same_root;

  logic               out_keep_r, out_invalid_r;
  logic [CELL_W-1:0]  out_first_r, out_second_r;
  logic [KEPT_W-1:0]  out_kept_r;

  // Clamp the grid size to the built forest
  always_comb begin
    cols = columns;
    rws  = rows;
    if ({2'b00, columns} > LIM_W'(MAX_COLUMNS)) begin
      cols = CFG_W'(MAX_COLUMNS);
    end
    if ({2'b00, rows} > LIM_W'(MAX_ROWS)) begin
      rws = CFG_W'(MAX_ROWS);
    end
  end

  // Form both cell indices and the off-grid flag
  always_comb begin
    bad_nxt = ({1'b0, x_r} >= cols) || ({1'b0, y_r} >= rws) ||
              (up_r ? (y_r == '0) : (x_r == '0));
    first_nxt  = IDX_W'(y_r) * IDX_W'(cols) + IDX_W'(x_r);
    second_nxt = up_r ? (first_nxt - IDX_W'(cols)) : (first_nxt - IDX_W'(1));
  end

  assign rd_parent = rd_data_r[ENT_W-1:RANK_W];
  assign rd_rank   = rd_data_r[RANK_W-1:0];
  assign at_root   = (rd_parent == node_r);
  assign same_root = (root_a_r == node_r);

  // Select the read address and the node being walked
  always_comb begin
    rd_addr  = rd_parent;
    node_nxt = node_r;
    if (cmd.rd_first) begin
      rd_addr  = IW'(first_r);
      node_nxt = IW'(first_r);
    end else if (cmd.rd_second) begin
      rd_addr  = IW'(second_r);
      node_nxt = IW'(second_r);
    end else if ((cmd.walk_a || cmd.walk_b) && !at_root) begin
      node_nxt = rd_parent;
    end
  end

  // Select the write: clearing sweep, link of two roots, or rank bump
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = {clr_cnt_r, {RANK_W{1'b0}}};
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.do_merge && !same_root) begin
      wr_en = 1'b1;
      if (rank_a_r < rank_b_r) begin
        wr_addr = root_a_r;
        wr_data = {node_r, rank_a_r};
      end else begin
        wr_addr = node_r;
        wr_data = {root_a_r, rank_b_r};
      end
    end else if (cmd.bump) begin
      wr_en   = 1'b1;
      wr_addr = root_a_r;
      wr_data = {root_a_r, (rank_a_r == RANK_MAX) ? rank_a_r : rank_a_r + RANK_W'(1)};
    end
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control state: sweep counter and kept count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      kept_r    <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + IW'(1);
        kept_r    <= '0;
      end else if (cmd.do_merge && same_root && (kept_r != KEPT_MAX)) begin
        kept_r <= kept_r + KEPT_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r  <= in_cell_x;
      y_r  <= in_cell_y;
      up_r <= in_orientation;
    end
    if (cmd.calc) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      bad_r    <= bad_nxt;
      keep_r   <= 1'b0;
    end
    if (cmd.do_merge) begin
      keep_r <= same_root;
    end
    node_r <= node_nxt;
    if (cmd.walk_a && at_root) begin
      root_a_r <= node_r;
      rank_a_r <= rd_rank;
    end
    if (cmd.walk_b && at_root) begin
      rank_b_r <= rd_rank;
    end
    if (cmd.out_load) begin
      out_keep_r    <= keep_r;
      out_first_r   <= bad_r ? '0 : first_r[CELL_W-1:0];
      out_second_r  <= bad_r ? '0 : second_r[CELL_W-1:0];
      out_invalid_r <= bad_r;
      out_kept_r    <= kept_r;
    end
  end

  always_comb begin
    sts           = '0;
    sts.clr_last  = (clr_cnt_r == IW'(CELL_COUNT - 1));
    sts.bad       = bad_r;
    sts.at_root   = at_root;
    sts.bump_need = !same_root && (rank_a_r == rank_b_r);
  end

  assign out_keep        = out_keep_r;
  assign out_first_cell  = out_first_r;
  assign out_second_cell = out_second_r;
  assign out_invalid     = out_invalid_r;
  assign out_walls_kept  = out_kept_r;

endmodule

FILE: design/maze_wall_union_find_core.sv
// Maze wall filter: a union-find forest over the grid cells decides, wall by
// wall in shuffled order, whether a wall is removed or kept.
// Input channel (in_*): one wall per transfer, first cell by column and row,
// orientation 0 toward the left neighbor, 1 toward the neighbor above;
// in_restart clears the forest and the kept count before this wall.
// Output channel (out_*): one result per wall: keep flag, both linear cell
// indices, off-grid flag and the running kept count.
// Configuration: cfg_wr_en with cfg_index 0 writes columns, 1 writes rows;
// write only while the block is idle.
// Work per wall: an off-grid wall goes from its index calculation straight to
// its result. A valid wall walks the parent links from each cell to its root,
// then links the two roots if they differ, with a rank bump when two roots of
// equal rank are joined; the forest memory gives one link per cycle. A walk is
// short (union by rank). One wall is in work at a time.
// A restart adds one sweep over all MAX_COLUMNS * MAX_ROWS entries of the
// forest memory (4096 at the default sizes).
// Reset: the same sweep runs after reset; in_stall stays high until it ends.
// The result sits in an output register; while out_stall is high it holds
// and the next wall is still taken and worked up to its result.
module maze_wall_union_find_core #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  mwuf_pkg::cfg_idx_t            cfg_index,
  input  logic [mwuf_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_restart,
  input  logic [mwuf_pkg::COORD_W-1:0]  in_cell_x,
  input  logic [mwuf_pkg::COORD_W-1:0]  in_cell_y,
  input  logic                          in_orientation,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_keep,
  output logic [mwuf_pkg::CELL_W-1:0]   out_first_cell,
  output logic [mwuf_pkg::CELL_W-1:0]   out_second_cell,
  output logic                          out_invalid,
  output logic [mwuf_pkg::KEPT_W-1:0]   out_walls_kept
);
  import mwuf_pkg::*;

  logic [CFG_W-1:0] columns_r, rows_r;
  cmd_t             cmd;
  sts_t             sts;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RESET;
      rows_r    <= ROWS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_COLUMNS: columns_r <= cfg_data;
        CFG_ROWS:    rows_r    <= cfg_data;
        default:     ;
      endcase
    end
  end

  mwuf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  mwuf_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .columns         (columns_r),
    .rows            (rows_r),
    .in_cell_x       (in_cell_x),
    .in_cell_y       (in_cell_y),
    .in_orientation  (in_orientation),
    .out_keep        (out_keep),
    .out_first_cell  (out_first_cell),
    .out_second_cell (out_second_cell),
    .out_invalid     (out_invalid),
    .out_walls_kept  (out_walls_kept)
  );

endmodule
